// ----- hdl/ssi_pkg.sv -----
// Shared constants and types for the SSI encoder reader.
`default_nettype none

package ssi_pkg;

    // Encoder word length and the toggle count at which a frame ends.
    localparam int DATA_BITS   = 14;
    localparam int CNT_W       = 6;
    localparam logic [CNT_W-1:0] LAST_TOGGLE = CNT_W'((DATA_BITS + 1) * 2);

    localparam int POS_W       = 14;
    localparam int SEQ_W       = 16;
    localparam int TS_W        = 32;
    localparam int STAMP_W     = 32;

    // Configuration register.
    localparam int CPU_W       = 10;
    localparam logic [CPU_W-1:0] CPU_RESET = CPU_W'(480);
    localparam int ADDR_W      = 3;
    localparam logic [ADDR_W-1:0] ADDR_CYCLES_PER_US = ADDR_W'(0);

    // Iterative divider: one quotient bit per step.
    localparam int DIV_STEPS   = STAMP_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Stream widths.
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 64;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_START  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } seq_state_t;

endpackage

`default_nettype wire

// ----- hdl/ssi_encoder_reader.sv -----
// SSI encoder master: tick-driven clock/shift sequencer with an iterative timestamp divider.
//
// Usage: each word on the slave stream is a timer tick (tuser = 0) or a start
// command (tuser = 1), with the sampled data line and a 32-bit core cycle stamp.
// Every accepted word produces exactly one result word on the master stream:
// the encoder clock level, and on the tick that ends a frame (tlast high) the
// 14-bit position, a wrapping frame number and the accumulated microseconds.
// Ordinary ticks and starts are answered in the cycle after acceptance, and the
// next word can follow right away when the result is taken.
// A frame-end tick runs a restoring division of the cycle delta by
// cycles_per_us, one quotient bit per cycle, then adds the quotient to the
// timestamp once the output register is free; s_tready is low meanwhile.
// cycles_per_us is written over the APB port (address 0); the user must write
// it only while the block is idle, as the block itself does not enforce this.
// A value of zero divides by one. Reset clears the sequencer, frame counter,
// timestamp and cycle stamp, and loads cycles_per_us with 480. While the
// receiver stalls, the result stays in the output register and no new word is accepted.
`default_nettype none

module ssi_encoder_reader
    import ssi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,  // [0] data_level, [32:1] cycle_stamp, rest zero
    input  wire logic [0:0]            s_tuser,  // [0] operation
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,  // [0] clock_level, [14:1] position,
                                                 // [30:15] sequence_res, [62:31] timestamp_us
    output logic                       m_tlast   // frame_done
);

    seq_state_t         state_reg, state_next;
    logic [CPU_W-1:0]   cpu_reg;
    logic               running_reg, running_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   shift_reg, shift_next;
    logic               clock_reg, clock_next;
    logic [SEQ_W-1:0]   frame_reg, frame_next;
    logic [TS_W-1:0]    elapsed_reg, elapsed_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_clock_reg, out_clock_next;
    logic               out_last_reg, out_last_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [SEQ_W-1:0]   out_seq_reg, out_seq_next;
    logic [TS_W-1:0]    out_ts_reg, out_ts_next;

    logic [STAMP_W-1:0] dq_reg, dq_next;
    logic [CPU_W-1:0]   rem_reg, rem_next;
    logic [CPU_W-1:0]   div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic               in_fire;
    logic               out_free;
    logic               in_level;
    logic [STAMP_W-1:0] in_stamp;
    logic [CNT_W-1:0]   count_inc;
    logic [CPU_W:0]     rem_shift;
    logic [CPU_W:0]     rem_diff;
    logic               cfg_write;

    assign in_level  = s_tdata[0];
    assign in_stamp  = s_tdata[STAMP_W:1];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign count_inc = count_reg + CNT_W'(1);
    assign rem_shift = {rem_reg, dq_reg[STAMP_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_CYCLES_PER_US);
    assign prdata    = (paddr == ADDR_CYCLES_PER_US) ? {{(32-CPU_W){1'b0}}, cpu_reg} : 32'd0;

    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {1'b0, out_ts_reg, out_seq_reg, out_pos_reg, out_clock_reg};

    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        shift_next     = shift_reg;
        clock_next     = clock_reg;
        frame_next     = frame_reg;
        elapsed_next   = elapsed_reg;
        stamp_next     = stamp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_clock_next = out_clock_reg;
        out_last_next  = out_last_reg;
        out_pos_next   = out_pos_reg;
        out_seq_next   = out_seq_reg;
        out_ts_next    = out_ts_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser[0] == OP_START)
                    begin
                        running_next = 1'b1;
                    end
                    else if (running_reg && (count_reg < LAST_TOGGLE))
                    begin
                        clock_next = !clock_reg;
                        count_next = count_inc;
                        if (count_inc[0] && (count_inc > CNT_W'(2)))
                        begin
                            shift_next = {shift_reg[POS_W-2:0], in_level};
                        end
                    end
                    else if (running_reg)
                    begin
                        // Frame end: book the frame now, the timestamp after the division.
                        stamp_next   = in_stamp;
                        running_next = 1'b0;
                        frame_next   = frame_reg + SEQ_W'(1);
                        pos_next     = shift_reg;
                        shift_next   = '0;
                        count_next   = '0;
                        dq_next      = in_stamp - stamp_reg;
                        rem_next     = '0;
                        div_next     = (cpu_reg == '0) ? CPU_W'(1) : cpu_reg;
                        step_next    = '0;
                        state_next   = ST_DIV;
                    end

                    if (!(running_reg && (s_tuser[0] == OP_TICK)
                          && (count_reg >= LAST_TOGGLE)))
                    begin
                        out_valid_next = 1'b1;
                        out_clock_next = clock_next;
                        out_last_next  = 1'b0;
                        out_pos_next   = '0;
                        out_seq_next   = '0;
                        out_ts_next    = '0;
                    end
                end
            end

            ST_DIV:
            begin
                // Restoring division; the quotient replaces the dividend bit by bit.
                if (!rem_diff[CPU_W])
                begin
                    rem_next = rem_diff[CPU_W-1:0];
                    dq_next  = {dq_reg[STAMP_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[CPU_W-1:0];
                    dq_next  = {dq_reg[STAMP_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    elapsed_next   = elapsed_reg + dq_reg;
                    out_valid_next = 1'b1;
                    out_clock_next = clock_reg;
                    out_last_next  = 1'b1;
                    out_pos_next   = pos_reg;
                    out_seq_next   = frame_reg;
                    out_ts_next    = elapsed_next;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cpu_reg       <= CPU_RESET;
            running_reg   <= 1'b0;
            count_reg     <= '0;
            shift_reg     <= '0;
            clock_reg     <= 1'b0;
            frame_reg     <= '0;
            elapsed_reg   <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            clock_reg     <= clock_next;
            frame_reg     <= frame_next;
            elapsed_reg   <= elapsed_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                cpu_reg <= pwdata[CPU_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_clock_reg <= out_clock_next;
        out_last_reg  <= out_last_next;
        out_pos_reg   <= out_pos_next;
        out_seq_reg   <= out_seq_next;
        out_ts_reg    <= out_ts_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        step_reg      <= step_next;
        pos_reg       <= pos_next;
    end

endmodule

`default_nettype wire

// ----- hdl/ssi_checker.sv -----
// Port-level assertions for the SSI encoder reader and their binding.
`default_nettype none

module ssi_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tlast
);

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A held result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A start command is answered in the next cycle and never ends a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> m_tvalid && !m_tlast)
        else $error("start command not answered in time");

    // Results that do not end a frame carry only the clock level.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[62:1] == 62'd0)
        else $error("frame fields set on a non-final result");

endmodule

bind ssi_encoder_reader ssi_checker u_ssi_checker (.*);

`default_nettype wire
